// ===== rtl/ir_remote_pulse_decoder_macros.svh =====
// Assertion macros shared by the IR pulse decoder RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef IR_REMOTE_PULSE_DECODER_MACROS_SVH
`define IR_REMOTE_PULSE_DECODER_MACROS_SVH

// Same-cycle implication, reset masked.
`define IRPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define IRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/irpd_pkg.sv =====
// Types, constants and window helpers for the IR pulse decoder.
// No dependencies; used by every other RTL file but the macros header.
package irpd_pkg;

  localparam int DUR_W  = 16;
  localparam int CODE_W = 32;
  localparam int IDX_W  = $clog2(CODE_W);

  localparam int MAX_PAIRS_DEF   = 34;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [DUR_W-1:0] TIMEOUT_RESET = 16'd20000;

  localparam int NEC_BITS  = 32;
  localparam int SONY_BITS = 12;

  // leader windows
  localparam logic [DUR_W-1:0] NEC_LEAD_MARK_LO  = 16'd8400;
  localparam logic [DUR_W-1:0] NEC_LEAD_MARK_HI  = 16'd10000;
  localparam logic [DUR_W-1:0] NEC_LEAD_SPACE_LO = 16'd3800;
  localparam logic [DUR_W-1:0] NEC_LEAD_SPACE_HI = 16'd4700;
  localparam logic [DUR_W-1:0] SONY_LEAD_MARK_LO = 16'd2000;
  localparam logic [DUR_W-1:0] SONY_LEAD_MARK_HI = 16'd2800;
  localparam logic [DUR_W-1:0] SONY_LEAD_SPACE_LO = 16'd100;
  localparam logic [DUR_W-1:0] SONY_LEAD_SPACE_HI = 16'd800;

  // data bit windows
  localparam logic [DUR_W-1:0] SHORT_LO      = 16'd100;
  localparam logic [DUR_W-1:0] NEC_SHORT_HI  = 16'd700;
  localparam logic [DUR_W-1:0] NEC_ONE_LO    = 16'd1200;
  localparam logic [DUR_W-1:0] NEC_ONE_HI    = 16'd1800;
  localparam logic [DUR_W-1:0] SONY_SHORT_HI = 16'd750;
  localparam logic [DUR_W-1:0] SONY_ONE_LO   = 16'd950;
  localparam logic [DUR_W-1:0] SONY_ONE_HI   = 16'd1400;

  typedef enum logic [1:0] {
    PROTO_UNKNOWN = 2'd0,
    PROTO_NEC     = 2'd1,
    PROTO_SONY    = 2'd2
  } proto_t;

  // classified pair, front -> back
  typedef struct packed {
    logic lead_nec;
    logic lead_sony;
    logic nec_hit;
    logic nec_val;
    logic sony_hit;
    logic sony_val;
    logic timeout;
  } pair_class_t;

  function automatic logic in_win(logic [DUR_W-1:0] v, logic [DUR_W-1:0] lo,
                                  logic [DUR_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

// ===== rtl/irpd_ifs.sv =====
// Valid/ready channel interfaces for pulse pairs in and decoded codes out.
// Depends on irpd_pkg for field widths.
interface irpd_pair_if;
  logic                          valid;
  logic                          ready;
  logic [irpd_pkg::DUR_W-1:0]    mark_len;
  logic [irpd_pkg::DUR_W-1:0]    space_len;

  modport source (output valid, output mark_len, output space_len, input ready);
  modport sink   (input valid, input mark_len, input space_len, output ready);
endinterface

interface irpd_code_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    protocol;
  logic [irpd_pkg::CODE_W-1:0]   code_out;

  modport source (output valid, output protocol, output code_out, input ready);
  modport sink   (input valid, input protocol, input code_out, output ready);
endinterface

// ===== rtl/irpd_front.sv =====
// Front end: holds timeout_limit and classifies each pulse pair against the
// protocol windows. Depends on irpd_pkg.
module irpd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [irpd_pkg::DUR_W-1:0]  cfg_wdata,
  input  logic [irpd_pkg::DUR_W-1:0]  mark_len,
  input  logic [irpd_pkg::DUR_W-1:0]  space_len,
  output irpd_pkg::pair_class_t       pair_class
);

  logic [irpd_pkg::DUR_W-1:0] timeout_r;
  logic [irpd_pkg::DUR_W-1:0] timeout_nxt;

  always_comb begin
    timeout_nxt = cfg_we ? cfg_wdata : timeout_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= irpd_pkg::TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  logic nec_one;
  logic sony_one;

  always_comb begin
    nec_one  = irpd_pkg::in_win(space_len, irpd_pkg::NEC_ONE_LO, irpd_pkg::NEC_ONE_HI);
    sony_one = irpd_pkg::in_win(mark_len, irpd_pkg::SONY_ONE_LO, irpd_pkg::SONY_ONE_HI);

    pair_class.lead_nec =
      irpd_pkg::in_win(mark_len, irpd_pkg::NEC_LEAD_MARK_LO, irpd_pkg::NEC_LEAD_MARK_HI) &&
      irpd_pkg::in_win(space_len, irpd_pkg::NEC_LEAD_SPACE_LO, irpd_pkg::NEC_LEAD_SPACE_HI);
    pair_class.lead_sony =
      irpd_pkg::in_win(mark_len, irpd_pkg::SONY_LEAD_MARK_LO, irpd_pkg::SONY_LEAD_MARK_HI) &&
      irpd_pkg::in_win(space_len, irpd_pkg::SONY_LEAD_SPACE_LO,
                       irpd_pkg::SONY_LEAD_SPACE_HI);

    // NEC: short mark, space length carries the bit
    pair_class.nec_hit =
      irpd_pkg::in_win(mark_len, irpd_pkg::SHORT_LO, irpd_pkg::NEC_SHORT_HI) &&
      (irpd_pkg::in_win(space_len, irpd_pkg::SHORT_LO, irpd_pkg::NEC_SHORT_HI) || nec_one);
    pair_class.nec_val = nec_one;

    // Sony: short space, mark length carries the bit
    pair_class.sony_hit =
      irpd_pkg::in_win(space_len, irpd_pkg::SHORT_LO, irpd_pkg::SONY_SHORT_HI) &&
      (irpd_pkg::in_win(mark_len, irpd_pkg::SHORT_LO, irpd_pkg::SONY_SHORT_HI) || sony_one);
    pair_class.sony_val = sony_one;

    pair_class.timeout = (mark_len > timeout_r) || (space_len > timeout_r);
  end

endmodule

// ===== rtl/irpd_queue.sv =====
// Small FIFO of classified pairs between front and back end.
// Depends on irpd_pkg for the entry type.
module irpd_queue #(
  parameter int DEPTH = irpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  irpd_pkg::pair_class_t  push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output irpd_pkg::pair_class_t  pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  irpd_pkg::pair_class_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    full  = (count_r == CNT_W'(DEPTH));
    empty = (count_r == '0);

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr_r];

endmodule

// ===== rtl/irpd_back.sv =====
// Back end: frame sequencer that tracks pair count, protocol and code word
// and registers one result per frame. Depends on irpd_pkg and the macros.
`include "ir_remote_pulse_decoder_macros.svh"

module irpd_back #(
  parameter int MAX_PAIRS = irpd_pkg::MAX_PAIRS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  irpd_pkg::pair_class_t       q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_protocol,
  output logic [irpd_pkg::CODE_W-1:0] out_code
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  logic [CNT_W-1:0]            pair_cnt_r, pair_cnt_nxt;
  irpd_pkg::proto_t            proto_r, proto_nxt;
  logic [irpd_pkg::CODE_W-1:0] code_r, code_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_proto_r, out_proto_nxt;
  logic [irpd_pkg::CODE_W-1:0] out_code_r, out_code_nxt;

  irpd_pkg::proto_t            proto_cur;
  logic [CNT_W-1:0]            cnt_inc;
  logic [irpd_pkg::IDX_W-1:0]  nec_idx;
  logic [irpd_pkg::IDX_W-1:0]  sony_idx;
  logic                        end_frame;

  always_comb begin
    q_pop = !q_empty && (!out_valid_r || out_ready);

    nec_idx  = irpd_pkg::IDX_W'(CNT_W'(irpd_pkg::NEC_BITS) - pair_cnt_r);
    sony_idx = irpd_pkg::IDX_W'(CNT_W'(irpd_pkg::SONY_BITS) - pair_cnt_r);
    cnt_inc  = pair_cnt_r + 1'b1;

    code_nxt  = code_r;
    proto_cur = proto_r;
    if (pair_cnt_r == '0) begin
      if (q_data.lead_nec) begin
        proto_cur = irpd_pkg::PROTO_NEC;
      end else if (q_data.lead_sony) begin
        proto_cur = irpd_pkg::PROTO_SONY;
      end else begin
        proto_cur = irpd_pkg::PROTO_UNKNOWN;
      end
    end else begin
      unique case (proto_r)
        irpd_pkg::PROTO_NEC: begin
          if (pair_cnt_r <= CNT_W'(irpd_pkg::NEC_BITS) && q_data.nec_hit) begin
            code_nxt[nec_idx] = q_data.nec_val;
          end
        end
        irpd_pkg::PROTO_SONY: begin
          if (pair_cnt_r <= CNT_W'(irpd_pkg::SONY_BITS) && q_data.sony_hit) begin
            code_nxt[sony_idx] = q_data.sony_val;
          end
        end
        default: begin
        end
      endcase
    end

    end_frame = q_data.timeout || (cnt_inc >= CNT_W'(MAX_PAIRS));

    pair_cnt_nxt  = pair_cnt_r;
    proto_nxt     = proto_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_proto_nxt = out_proto_r;
    out_code_nxt  = out_code_r;

    if (q_pop) begin
      if (end_frame) begin
        pair_cnt_nxt  = '0;
        proto_nxt     = irpd_pkg::PROTO_UNKNOWN;
        out_valid_nxt = 1'b1;
        out_proto_nxt = proto_cur;
        out_code_nxt  = code_nxt;
      end else begin
        pair_cnt_nxt = cnt_inc;
        proto_nxt    = proto_cur;
      end
    end else begin
      code_nxt = code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_cnt_r  <= '0;
      proto_r     <= irpd_pkg::PROTO_UNKNOWN;
      code_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pair_cnt_r  <= pair_cnt_nxt;
      proto_r     <= proto_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_proto_r <= out_proto_nxt;
    out_code_r  <= out_code_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_protocol = out_proto_r;
  assign out_code     = out_code_r;

  `IRPD_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, pair_cnt_r < CNT_W'(MAX_PAIRS),
    "pair count reached MAX_PAIRS")
  `IRPD_ASSERT_NOW(a_idle_unknown, clk, rst_n, pair_cnt_r == '0,
    proto_r == irpd_pkg::PROTO_UNKNOWN, "protocol held with no frame open")
  `IRPD_ASSERT_NEXT(a_end_result, clk, rst_n, q_pop && end_frame,
    out_valid_r && pair_cnt_r == '0, "frame end did not post a result")
  `IRPD_ASSERT_NOW(a_no_pop_stalled, clk, rst_n, out_valid_r && !out_ready, !q_pop,
    "pair consumed while result stalled")

endmodule

// ===== rtl/ir_remote_pulse_decoder.sv =====
// IR remote pulse decoder (NEC and Sony SIRC): top level.
// Depends on irpd_pkg, irpd_ifs, irpd_front, irpd_queue and irpd_back.
//
// Takes measured mark/space durations (microseconds) one request per pair
// and reports one request per frame carrying the protocol (0 unknown, 1 NEC,
// 2 Sony) and the 32-bit code word. The leader pair picks the protocol; NEC
// data pairs 1..32 fill bits 31..0, Sony pairs 1..12 fill bits 11..0, and a
// pair outside every bit window leaves its bit as it was. The code word is
// not cleared between frames. A frame closes when mark or space exceeds
// timeout_limit (the closing pair is still decoded) or after MAX_PAIRS
// pairs. Throughput is one pair per clock while the FIFO has room: the front
// end classifies the pair combinationally and drops it in a QUEUE_DEPTH-entry
// FIFO, and the back-end sequencer retires one FIFO entry per cycle unless a
// result stalls. A result is registered as its closing pair is popped; while
// it waits at the output register the FIFO keeps absorbing pairs until full.
// timeout_limit (reset 20000) is written through cfg_we/cfg_wdata and should
// only change while no frame is in flight.
module ir_remote_pulse_decoder #(
  parameter int MAX_PAIRS   = irpd_pkg::MAX_PAIRS_DEF,
  parameter int QUEUE_DEPTH = irpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [irpd_pkg::DUR_W-1:0]  cfg_wdata,
  irpd_pair_if.sink                   in_pair,
  irpd_code_if.source                 out_code
);

  irpd_pkg::pair_class_t front_class;
  irpd_pkg::pair_class_t q_head;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic                  in_accept;

  // input side never waits on the result side beyond FIFO depth
  assign in_pair.ready = !q_full;
  assign in_accept     = in_pair.valid && !q_full;

  irpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mark_len   (in_pair.mark_len),
    .space_len  (in_pair.space_len),
    .pair_class (front_class)
  );

  irpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (front_class),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_head)
  );

  irpd_back #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_code.valid),
    .out_ready    (out_code.ready),
    .out_protocol (out_code.protocol),
    .out_code     (out_code.code_out)
  );

endmodule
